### hdl/nps_pkg.sv
// shared types and constants for the next-permutation stepper
package nps_pkg;

  // fixed field widths
  localparam int ElemW     = 3;
  localparam int IdxW      = 3;
  localparam int SizeW     = 4;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 8;

  // default store depth
  localparam int DefMaxElems = 8;

  // reset value of the size register
  localparam logic [SizeW-1:0] SizeReset = 4'd8;

  // request kinds carried in tuser
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_REV_RD,
    ST_REV_WR_LO,
    ST_REV_WR_HI,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SWP_WR_PIV,
    ST_SWP_WR_J,
    ST_EMIT_RD,
    ST_EMIT_PUT
  } state_t;

  // store access strobes
  typedef struct packed {
    logic ren;
    logic wen;
  } mem_ctl_t;

endpackage

### hdl/nps_store.sv
// element store: one write port, two registered read ports, identity on reset
module nps_store import nps_pkg::*; #(
  parameter int MAX_ELEMS = DefMaxElems
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mem_ctl_t                     ctl,
  input  logic [$clog2(MAX_ELEMS)-1:0] addr_a,
  input  logic [$clog2(MAX_ELEMS)-1:0] addr_b,
  input  logic [$clog2(MAX_ELEMS)-1:0] waddr,
  input  logic [ElemW-1:0]             wdata,
  output logic [ElemW-1:0]             rd_a,
  output logic [ElemW-1:0]             rd_b
);

  logic [ElemW-1:0]     mem [MAX_ELEMS];
  logic [MAX_ELEMS-1:0] valid;

  // entry array
  always_ff @(posedge clk) begin
    if (ctl.wen) begin
      mem[waddr] <= wdata;
    end
  end

  // written marks, unwritten entries read as their own position
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wen) begin
      valid[waddr] <= 1'b1;
    end
  end

  // registered reads, held while no read is requested
  always_ff @(posedge clk) begin
    if (ctl.ren) begin
      rd_a <= valid[addr_a] ? mem[addr_a] : ElemW'(addr_a);
      rd_b <= valid[addr_b] ? mem[addr_b] : ElemW'(addr_b);
    end
  end

endmodule

### hdl/nps_ctrl.sv
// sequencer: pivot scan, suffix reversal, swap search, emit, output register
module nps_ctrl import nps_pkg::*; #(
  parameter int MAX_ELEMS = DefMaxElems
) (
  input  logic                         clk,
  input  logic                         rst,
  // request side
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [IdxW-1:0]              in_index,
  input  logic [ElemW-1:0]             in_value,
  // result side
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ElemW-1:0]             out_element,
  output logic [IdxW-1:0]              out_position,
  output logic                         out_wrapped,
  output logic                         out_last,
  // size register
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [SizeW-1:0]             cfg_data,
  // store port
  output mem_ctl_t                     mctl,
  output logic [$clog2(MAX_ELEMS)-1:0] addr_a,
  output logic [$clog2(MAX_ELEMS)-1:0] addr_b,
  output logic [$clog2(MAX_ELEMS)-1:0] waddr,
  output logic [ElemW-1:0]             wdata,
  input  logic [ElemW-1:0]             rd_a,
  input  logic [ElemW-1:0]             rd_b
);

  localparam int AW = $clog2(MAX_ELEMS);

  state_t          state, state_next;
  logic [SizeW-1:0] size_in_use;
  logic [AW-1:0]   nm1, piv, lo, hi, j, k;
  logic            wrapped;

  logic            in_acc, adv_acc, load_acc, out_free;
  logic [4:0]      n_clamp;
  logic [AW-1:0]   nm1_calc, lo_inc, hi_dec;
  logic            rev_found, srch_more;

  // handshakes
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign adv_acc   = in_acc && (in_mode == MODE_ADVANCE);
  assign load_acc  = in_acc && (in_mode == MODE_LOAD) &&
                     ({2'b00, in_index} < 5'(MAX_ELEMS));
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // element count clamped to 1 .. MAX_ELEMS
  always_comb begin
    n_clamp = {1'b0, size_in_use};
    if (n_clamp == 5'd0) begin
      n_clamp = 5'd1;
    end
    if (n_clamp > 5'(MAX_ELEMS)) begin
      n_clamp = 5'(MAX_ELEMS);
    end
    nm1_calc = AW'(n_clamp - 5'd1);
  end

  // loop conditions
  assign rev_found = (rd_a <= rd_b);
  assign lo_inc    = lo + AW'(1);
  assign hi_dec    = hi - AW'(1);
  assign srch_more = (j < nm1) && (rd_b < rd_a);

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SizeReset;
    end else if (cfg_valid && cfg_ready) begin
      size_in_use <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (adv_acc) begin
          state_next = (nm1_calc == '0) ? ST_EMIT_RD : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (rev_found) begin
          state_next = (piv < nm1) ? ST_REV_RD : ST_SRCH_RD;
        end else if (piv == AW'(1)) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_REV_RD:    state_next = ST_REV_WR_LO;
      ST_REV_WR_LO: state_next = ST_REV_WR_HI;
      ST_REV_WR_HI: state_next = (lo_inc < hi_dec) ? ST_REV_RD : ST_SRCH_RD;
      ST_SRCH_RD:   state_next = ST_SRCH_CMP;
      ST_SRCH_CMP:  state_next = srch_more ? ST_SRCH_RD : ST_SWP_WR_PIV;
      ST_SWP_WR_PIV: state_next = ST_SWP_WR_J;
      ST_SWP_WR_J:  state_next = ST_EMIT_RD;
      ST_EMIT_RD:   state_next = ST_EMIT_PUT;
      ST_EMIT_PUT: begin
        if (out_free) begin
          state_next = (k == nm1) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // store accesses per state
  always_comb begin
    mctl   = '0;
    addr_a = piv;
    addr_b = piv;
    waddr  = lo;
    wdata  = rd_b;
    case (state)
      ST_IDLE: begin
        mctl.wen = load_acc;
        waddr    = AW'(in_index);
        wdata    = in_value;
      end
      ST_SCAN_RD: begin
        mctl.ren = 1'b1;
        addr_a   = piv - AW'(1);
        addr_b   = piv;
      end
      ST_REV_RD: begin
        mctl.ren = 1'b1;
        addr_a   = lo;
        addr_b   = hi;
      end
      ST_REV_WR_LO: begin
        mctl.wen = 1'b1;
        waddr    = lo;
        wdata    = rd_b;
      end
      ST_REV_WR_HI: begin
        mctl.wen = 1'b1;
        waddr    = hi;
        wdata    = rd_a;
      end
      ST_SRCH_RD: begin
        mctl.ren = 1'b1;
        addr_a   = piv;
        addr_b   = j;
      end
      ST_SWP_WR_PIV: begin
        mctl.wen = 1'b1;
        waddr    = piv;
        wdata    = rd_b;
      end
      ST_SWP_WR_J: begin
        mctl.wen = 1'b1;
        waddr    = j;
        wdata    = rd_a;
      end
      ST_EMIT_RD: begin
        mctl.ren = 1'b1;
        addr_a   = k;
      end
      default: begin
        mctl = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pointers and wrap flag
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (adv_acc) begin
          nm1     <= nm1_calc;
          piv     <= nm1_calc;
          k       <= '0;
          wrapped <= (nm1_calc == '0);
        end
      end
      ST_SCAN_CMP: begin
        piv <= piv - AW'(1);
        if (rev_found) begin
          lo <= piv;
          hi <= nm1;
          j  <= piv;
        end else if (piv == AW'(1)) begin
          wrapped <= 1'b1;
        end
      end
      ST_REV_WR_HI: begin
        lo <= lo_inc;
        hi <= hi_dec;
      end
      ST_SRCH_CMP: begin
        if (srch_more) begin
          j <= j + AW'(1);
        end
      end
      ST_EMIT_PUT: begin
        if (out_free) begin
          k <= k + AW'(1);
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

  // output register, valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT_PUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register, payload
  always_ff @(posedge clk) begin
    if (state == ST_EMIT_PUT && out_free) begin
      out_element  <= rd_a;
      out_position <= IdxW'(k);
      out_wrapped  <= wrapped;
      out_last     <= (k == nm1);
    end
  end

endmodule

### hdl/next_permutation_stepper.sv
// top level of the lexicographic next-permutation stepper
//
//   channel  | signals                              | carries
//   ---------+--------------------------------------+----------------------------------
//   s_axis   | tvalid tready tdata[7:0] tuser       | load or advance request
//   m_axis   | tvalid tready tdata[7:0] tuser tlast | one element of the permutation
//   cfg      | cfg_valid cfg_ready cfg_data[3:0]    | size_in_use register write
//
// a load is written into the store as it is taken; an advance runs the pivot scan,
// suffix reversal, partner search and emit steps, or only the scan and emit steps
// with no successor, split up by the single write port and registered reads of the store
// reset restores the identity permutation and size 8 at once, no clearing pass
// a stalled result side holds the sequencer in its emit step; the next request
// is taken once the last element sits in the output register
module next_permutation_stepper import nps_pkg::*; #(
  parameter int MAX_ELEMS = DefMaxElems
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // index[2:0], value[5:3], zero[7:6]
  input  logic                s_axis_tuser,   // mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // element[2:0], position[5:3], zero[7:6]
  output logic                m_axis_tuser,   // wrapped
  output logic                m_axis_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SizeW-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_ELEMS);

  mem_ctl_t         mctl;
  logic [AW-1:0]    addr_a, addr_b, waddr;
  logic [ElemW-1:0] wdata, rd_a, rd_b;
  logic [ElemW-1:0] out_element;
  logic [IdxW-1:0]  out_position;

  // sequencer
  nps_ctrl #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_mode     (s_axis_tuser),
    .in_index    (s_axis_tdata[2:0]),
    .in_value    (s_axis_tdata[5:3]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_element (out_element),
    .out_position(out_position),
    .out_wrapped (m_axis_tuser),
    .out_last    (m_axis_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mctl        (mctl),
    .addr_a      (addr_a),
    .addr_b      (addr_b),
    .waddr       (waddr),
    .wdata       (wdata),
    .rd_a        (rd_a),
    .rd_b        (rd_b)
  );

  // element store
  nps_store #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mctl),
    .addr_a(addr_a),
    .addr_b(addr_b),
    .waddr (waddr),
    .wdata (wdata),
    .rd_a  (rd_a),
    .rd_b  (rd_b)
  );

  // result packing
  assign m_axis_tdata = {2'b00, out_position, out_element};

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the next-permutation stepper: directed and random requests
module testbench;
  import nps_pkg::*;

  localparam int StoreDepth   = DefMaxElems;
  localparam int SettleCycles = 80;
  localparam int StallLimit   = 2000;
  localparam int RandomItems  = 136;

  // one emitted element as the result side should show it
  typedef struct packed {
    logic [ElemW-1:0] element;
    logic [IdxW-1:0]  position;
    logic             wrapped;
    logic             is_last;
  } perm_beat_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // index[2:0], value[5:3], zero[7:6]
  logic                s_axis_tuser;   // mode
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // element[2:0], position[5:3], zero[7:6]
  logic                m_axis_tuser;   // wrapped
  logic                m_axis_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SizeW-1:0]    cfg_data;

  next_permutation_stepper #(
    .MAX_ELEMS(StoreDepth)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // mirror of the block state and the elements still owed
  logic [ElemW-1:0] perm_mirror [StoreDepth];
  logic [SizeW-1:0] size_mirror;
  perm_beat_t       pending_beats [$];
  perm_beat_t       want_beat;
  bit               calm;
  int               errors;
  int               n_loads;
  int               n_advances;
  int               n_wraps;
  int               n_beats;
  int               n_size_writes;
  int               idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic swap_entries(input int a, input int b);
    logic [ElemW-1:0] t;
    t = perm_mirror[a];
    perm_mirror[a] = perm_mirror[b];
    perm_mirror[b] = t;
  endtask

  // step the mirror to its successor and queue the emitted run
  task automatic step_to_successor();
    int n;
    int piv;
    int lo;
    int hi;
    int j;
    bit found;
    perm_beat_t beat;
    n = size_mirror;
    if (n < 1) n = 1;
    if (n > StoreDepth) n = StoreDepth;
    found = 1'b0;
    piv = n - 1;
    while (piv > 0 && !found) begin
      if (perm_mirror[piv-1] <= perm_mirror[piv]) found = 1'b1;
      piv--;
    end
    if (found) begin
      // reverse the suffix, then swap the pivot with its partner
      lo = piv + 1;
      hi = n - 1;
      while (lo < hi) begin
        swap_entries(lo, hi);
        lo++;
        hi--;
      end
      j = piv + 1;
      while (j < n - 1 && perm_mirror[j] < perm_mirror[piv]) j++;
      swap_entries(piv, j);
    end else begin
      n_wraps++;
    end
    for (int k = 0; k < n; k++) begin
      beat.element  = perm_mirror[k];
      beat.position = k[IdxW-1:0];
      beat.wrapped  = !found;
      beat.is_last  = (k == n - 1);
      pending_beats.push_back(beat);
    end
  endtask

  // send one request and update the mirror when it is taken
  task automatic send_request(input logic kind, input logic [IdxW-1:0] idx,
                              input logic [ElemW-1:0] val);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, val, idx};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    if (kind == MODE_LOAD) begin
      perm_mirror[idx] = val;
      n_loads++;
    end else begin
      n_advances++;
      step_to_successor();
    end
  endtask

  // let every owed element arrive, then give a trailing load time to finish
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_size(input logic [SizeW-1:0] sz);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    size_mirror = sz;
    n_size_writes++;
  endtask

  // identity after reset, full size
  task automatic test_identity_start();
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
    send_request(MODE_ADVANCE, 3'd7, 3'd7);
  endtask

  // descending run has no successor; a load outside the run leaves it alone
  task automatic test_no_successor();
    write_size(4'd3);
    send_request(MODE_LOAD, 3'd0, 3'd2);
    send_request(MODE_LOAD, 3'd1, 3'd1);
    send_request(MODE_LOAD, 3'd2, 3'd0);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
    send_request(MODE_LOAD, 3'd7, 3'd7);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
  endtask

  // size zero and one emit a single wrapped element, oversize saturates
  task automatic test_size_extremes();
    write_size(4'd0);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
    write_size(4'd1);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
    write_size(4'd15);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
    write_size(4'd2);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
  endtask

  // equal values in the store, partner search falling back to the end
  task automatic test_repeated_values();
    write_size(4'd4);
    for (int k = 0; k < 4; k++) send_request(MODE_LOAD, IdxW'(k), 3'd5);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
    send_request(MODE_LOAD, 3'd3, 3'd0);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
    send_request(MODE_LOAD, 3'd0, 3'd6);
    send_request(MODE_ADVANCE, 3'd0, 3'd0);
  endtask

  // random phases: pick a size, load a shuffled or noisy store, step it
  task automatic test_random_walks();
    logic [ElemW-1:0] deck [StoreDepth];
    logic [ElemW-1:0] t;
    logic [SizeW-1:0] sz;
    int sent;
    int pick;
    sent = 0;
    while (sent < RandomItems) begin
      if (sent >= RandomItems - 30) calm = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick == 0) sz = SizeW'($urandom_range(0, 1));
      else if (pick == 1) sz = SizeW'($urandom_range(9, 15));
      else sz = SizeW'($urandom_range(2, 8));
      write_size(sz);
      pick = $urandom_range(0, 7);
      if (pick < 6) begin
        // distinct values over the whole store, sometimes in descending order
        for (int k = 0; k < StoreDepth; k++) deck[k] = ElemW'(k);
        if (pick == 0) begin
          for (int k = 0; k < StoreDepth; k++) deck[k] = ElemW'(StoreDepth - 1 - k);
        end else begin
          for (int k = StoreDepth - 1; k > 0; k--) begin
            pick = $urandom_range(0, k);
            t = deck[k];
            deck[k] = deck[pick];
            deck[pick] = t;
          end
        end
        for (int k = 0; k < StoreDepth; k++) begin
          send_request(MODE_LOAD, IdxW'(k), deck[k]);
          sent++;
        end
      end else begin
        // a few arbitrary loads, duplicates likely
        repeat ($urandom_range(1, 6)) begin
          send_request(MODE_LOAD, IdxW'($urandom_range(0, 7)), ElemW'($urandom_range(0, 7)));
          sent++;
        end
      end
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(0, 7) == 0) begin
          send_request(MODE_LOAD, IdxW'($urandom_range(0, 7)), ElemW'($urandom_range(0, 7)));
          sent++;
        end
        send_request(MODE_ADVANCE, IdxW'($urandom_range(0, 7)),
                     ElemW'($urandom_range(0, 7)));
        sent++;
      end
    end
  endtask

  // result side stalls in random bursts
  initial begin
    m_axis_tready <= 1'b0;
    repeat (10) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // compare each accepted element with the oldest one owed
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_beats++;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected element %0d at position %0d",
                                  m_axis_tdata[2:0], m_axis_tdata[5:3]));
      end else begin
        want_beat = pending_beats.pop_front();
        if (m_axis_tdata[2:0] !== want_beat.element)
          report_mismatch($sformatf("element at position %0d: got %0d, expected %0d",
                                    want_beat.position, m_axis_tdata[2:0], want_beat.element));
        if (m_axis_tdata[5:3] !== want_beat.position)
          report_mismatch($sformatf("position: got %0d, expected %0d",
                                    m_axis_tdata[5:3], want_beat.position));
        if (m_axis_tuser !== want_beat.wrapped)
          report_mismatch($sformatf("wrapped at position %0d: got %0b, expected %0b",
                                    want_beat.position, m_axis_tuser, want_beat.wrapped));
        if (m_axis_tlast !== want_beat.is_last)
          report_mismatch($sformatf("last at position %0d: got %0b, expected %0b",
                                    want_beat.position, m_axis_tlast, want_beat.is_last));
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(negedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles, %0d elements still owed",
             StallLimit, pending_beats.size());
    $display("Simulation FAILED");
    $finish;
  end

  // reset, run the tests in turn, then report
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_LOAD;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    calm          = 1'b0;
    errors        = 0;
    n_loads       = 0;
    n_advances    = 0;
    n_wraps       = 0;
    n_beats       = 0;
    n_size_writes = 0;
    for (int k = 0; k < StoreDepth; k++) perm_mirror[k] = ElemW'(k);
    size_mirror = SizeReset;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_start();
    test_no_successor();
    test_size_extremes();
    test_repeated_values();
    test_random_walks();
    settle_idle();

    $display("covered %0d loads and %0d advances (%0d without successor), %0d elements checked",
             n_loads, n_advances, n_wraps, n_beats);
    $display("size register written %0d times, zero through fifteen, with %0d errors",
             n_size_writes, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
